// ----- rtl/dcb_pkg.sv -----
// ----------------------------------------------------------------------------
// dcb_pkg
// Shared types and constants of the dc blocking biquad cascade: register
// indexes, multiply-accumulate term codes, controller command and status.
// ----------------------------------------------------------------------------
`default_nettype none

package dcb_pkg;

  // coefficient registers are fixed Q2.30 words
  localparam int COEF_W    = 32;
  localparam int CFG_IDX_W = 8;

  // section index covers the largest supported cascade
  localparam int SEC_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_B0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_B1 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_A1 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_A2 = CFG_IDX_W'(3);

  // one product term of a section
  typedef enum logic [2:0] {
    TERM_B0X  = 3'd0,
    TERM_B1X1 = 3'd1,
    TERM_B0X2 = 3'd2,
    TERM_A1Y1 = 3'd3,
    TERM_A2Y2 = 3'd4
  } term_t;

  // controller to datapath
  typedef struct packed {
    logic                 load;
    logic                 mac;
    term_t                term;
    logic [SEC_IDX_W-1:0] section;
    logic                 round;
    logic                 last;
    logic                 finish;
  } dcb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } dcb_status_t;

endpackage

`default_nettype wire

// ----- rtl/dcb_if.sv -----
// ----------------------------------------------------------------------------
// dcb_if
// Channel interfaces: sample requests in, filtered sample requests out, and
// coefficient register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface dcb_in_if #(
  parameter int SAMPLE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;
  logic                           restart;
  logic                           block_end_in;

  modport source (output valid, sample_in, restart, block_end_in, input ready);
  modport sink   (input valid, sample_in, restart, block_end_in, output ready);
endinterface

interface dcb_out_if #(
  parameter int SAMPLE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic                           block_end_out;

  modport source (output valid, sample_out, block_end_out, input ready);
  modport sink   (input valid, sample_out, block_end_out, output ready);
endinterface

interface dcb_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [dcb_pkg::CFG_IDX_W-1:0]    index;
  logic [dcb_pkg::COEF_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/dc_block_biquad_cascade.sv -----
// ----------------------------------------------------------------------------
// dc_block_biquad_cascade
// DC blocking high-pass filter: a cascade of identical second-order sections
// with shared Q2.30 coefficients, one shared multiplier.
//
//   channel  dir  handshake      payload
//   din      in   valid/ready    sample_in, restart, block_end_in
//   dout     out  valid/ready    sample_out, block_end_out
//   cfg      in   valid/ready    index, data (b0, b1, a1, a2)
//
// Each section of a sample takes five multiply-accumulates through the one
// multiplier, a drain step and a rounding step; the result is then handed to
// the output register.
// Reset clears coefficients, histories, the sequencer and the output valid.
// din is ready only while the sequencer is idle; a finished result sits in the
// output register, and the next sample is taken while it waits for dout.
// cfg is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module dc_block_biquad_cascade #(
  parameter int SAMPLE_WIDTH   = 32,
  parameter int COEF_FRAC_BITS = 30,
  parameter int SECTION_COUNT  = 2
) (
  input  wire logic clk,
  input  wire logic rst,
  dcb_in_if.sink    din,
  dcb_out_if.source dout,
  dcb_cfg_if.sink   cfg
);

  dcb_pkg::dcb_cmd_t    cmd;
  dcb_pkg::dcb_status_t status;

  assign cfg.ready = 1'b1;

  // sequencer
  dcb_ctrl #(
    .SECTION_COUNT (SECTION_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .in_ready (din.ready),
    .cmd      (cmd),
    .status   (status)
  );

  // arithmetic and storage
  dcb_datapath #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .SECTION_COUNT  (SECTION_COUNT)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .sample_in     (din.sample_in),
    .restart       (din.restart),
    .block_end_in  (din.block_end_in),
    .out_valid     (dout.valid),
    .out_ready     (dout.ready),
    .sample_out    (dout.sample_out),
    .block_end_out (dout.block_end_out),
    .cfg_valid     (cfg.valid),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data)
  );

endmodule

`default_nettype wire

// ----- rtl/dcb_ctrl.sv -----
// ----------------------------------------------------------------------------
// dcb_ctrl
// Sequencer of the cascade: steps five multiply-accumulates, a drain and a
// rounding per section, then hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dcb_ctrl #(
  parameter int SECTION_COUNT = 2
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output dcb_pkg::dcb_cmd_t       cmd,
  input  wire dcb_pkg::dcb_status_t status
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_MAC    = 5'b00010,
    ST_DRAIN  = 5'b00100,
    ST_ROUND  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  localparam logic [dcb_pkg::SEC_IDX_W-1:0] LAST_SEC =
    dcb_pkg::SEC_IDX_W'(SECTION_COUNT - 1);

  state_t                          state, state_next;
  dcb_pkg::term_t                  term, term_next;
  logic [dcb_pkg::SEC_IDX_W-1:0]   section, section_next;
  logic                            is_last;

  assign is_last  = (section == LAST_SEC);
  assign in_ready = (state == ST_IDLE);

  // next state and commands
  always_comb begin
    state_next   = state;
    term_next    = term;
    section_next = section;
    cmd          = '0;
    cmd.term     = term;
    cmd.section  = section;
    cmd.last     = is_last;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load     = 1'b1;
          term_next    = dcb_pkg::TERM_B0X;
          section_next = '0;
          state_next   = ST_MAC;
        end
      end
      ST_MAC: begin
        cmd.mac = 1'b1;
        if (term == dcb_pkg::TERM_A2Y2) begin
          state_next = ST_DRAIN;
        end else begin
          term_next = dcb_pkg::term_t'(term + 3'd1);
        end
      end
      ST_DRAIN: begin
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        if (is_last) begin
          state_next = ST_FINISH;
        end else begin
          section_next = section + 1'b1;
          term_next    = dcb_pkg::TERM_B0X;
          state_next   = ST_MAC;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      term    <= dcb_pkg::TERM_B0X;
      section <= '0;
    end else begin
      state   <= state_next;
      term    <= term_next;
      section <= section_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/dcb_datapath.sv -----
// ----------------------------------------------------------------------------
// dcb_datapath
// Coefficient registers, history registers, one shared multiplier with a
// registered product, wide accumulator, round and saturate, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dcb_datapath #(
  parameter int SAMPLE_WIDTH   = 32,
  parameter int COEF_FRAC_BITS = 30,
  parameter int SECTION_COUNT  = 2
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire dcb_pkg::dcb_cmd_t                 cmd,
  output dcb_pkg::dcb_status_t                   status,
  // sample request fields
  input  wire logic signed [SAMPLE_WIDTH-1:0]    sample_in,
  input  wire logic                              restart,
  input  wire logic                              block_end_in,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]         sample_out,
  output logic                                   block_end_out,
  // register writes
  input  wire logic                              cfg_valid,
  input  wire logic [dcb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dcb_pkg::COEF_W-1:0]        cfg_data
);

  localparam int PROD_W = SAMPLE_WIDTH + dcb_pkg::COEF_W;
  localparam int ACC_W  = (SAMPLE_WIDTH + dcb_pkg::COEF_W + 3 > COEF_FRAC_BITS + 2) ?
                          SAMPLE_WIDTH + dcb_pkg::COEF_W + 3 : COEF_FRAC_BITS + 2;
  localparam int LEVELS = SECTION_COUNT + 1;
  localparam int LVL_W  = $clog2(LEVELS);
  localparam logic signed [ACC_W-1:0] HALF =
    ACC_W'(64'd1 << (COEF_FRAC_BITS - 1));
  localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic [LVL_W-1:0] TOP_LVL = LVL_W'(SECTION_COUNT);

  logic signed [dcb_pkg::COEF_W-1:0] b0_coef, b1_coef, a1_coef, a2_coef;
  logic signed [SAMPLE_WIDTH-1:0]    hist [LEVELS][2];
  logic signed [SAMPLE_WIDTH-1:0]    x_reg;
  logic                              block_end_reg;
  logic signed [PROD_W-1:0]          prod;
  logic                              prod_vld;
  logic                              prod_sub;
  logic signed [ACC_W-1:0]           acc;

  logic [LVL_W-1:0]                  lvl_in, lvl_out;
  logic signed [dcb_pkg::COEF_W-1:0] mul_coef;
  logic signed [SAMPLE_WIDTH-1:0]    mul_data;
  logic                              mul_sub;
  logic signed [ACC_W-1:0]           prod_ext;
  logic signed [ACC_W-1:0]           rnd, shf;
  logic [ACC_W-SAMPLE_WIDTH:0]       hi_bits;
  logic signed [SAMPLE_WIDTH-1:0]    y;

  assign status.out_free = !out_valid || out_ready;

  // coefficient registers, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      b0_coef <= '0;
      b1_coef <= '0;
      a1_coef <= '0;
      a2_coef <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        dcb_pkg::CFG_B0: b0_coef <= cfg_data;
        dcb_pkg::CFG_B1: b1_coef <= cfg_data;
        dcb_pkg::CFG_A1: a1_coef <= cfg_data;
        dcb_pkg::CFG_A2: a2_coef <= cfg_data;
        default: ;
      endcase
    end
  end

  // operand select for the current term
  assign lvl_in  = LVL_W'(cmd.section);
  assign lvl_out = lvl_in + 1'b1;

  always_comb begin
    mul_coef = b0_coef;
    mul_data = x_reg;
    mul_sub  = 1'b0;
    unique case (cmd.term)
      dcb_pkg::TERM_B0X: begin
        mul_coef = b0_coef;
        mul_data = x_reg;
      end
      dcb_pkg::TERM_B1X1: begin
        mul_coef = b1_coef;
        mul_data = hist[lvl_in][0];
      end
      dcb_pkg::TERM_B0X2: begin
        mul_coef = b0_coef;
        mul_data = hist[lvl_in][1];
      end
      dcb_pkg::TERM_A1Y1: begin
        mul_coef = a1_coef;
        mul_data = hist[lvl_out][0];
        mul_sub  = 1'b1;
      end
      dcb_pkg::TERM_A2Y2: begin
        mul_coef = a2_coef;
        mul_data = hist[lvl_out][1];
        mul_sub  = 1'b1;
      end
      default: ;
    endcase
  end

  // registered product
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= cmd.mac;
    end
    prod     <= mul_coef * mul_data;
    prod_sub <= mul_sub;
  end

  // accumulate, cleared on load and after each rounding
  assign prod_ext = ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (cmd.load || cmd.round) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= prod_sub ? acc - prod_ext : acc + prod_ext;
    end
  end

  // round to nearest, drop fraction, saturate
  assign rnd     = acc + HALF;
  assign shf     = rnd >>> COEF_FRAC_BITS;
  assign hi_bits = shf[ACC_W-1:SAMPLE_WIDTH-1];

  always_comb begin
    if ((&hi_bits) || !(|hi_bits)) begin
      y = shf[SAMPLE_WIDTH-1:0];
    end else if (shf[ACC_W-1]) begin
      y = SAT_MIN;
    end else begin
      y = SAT_MAX;
    end
  end

  // section input and histories
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < LEVELS; l++) begin
        hist[l][0] <= '0;
        hist[l][1] <= '0;
      end
    end else if (cmd.load) begin
      if (restart) begin
        for (int l = 0; l < LEVELS; l++) begin
          hist[l][0] <= '0;
          hist[l][1] <= '0;
        end
      end
    end else if (cmd.round) begin
      hist[lvl_in][1] <= hist[lvl_in][0];
      hist[lvl_in][0] <= x_reg;
      if (cmd.last) begin
        hist[TOP_LVL][1] <= hist[TOP_LVL][0];
        hist[TOP_LVL][0] <= y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_reg         <= sample_in;
      block_end_reg <= block_end_in;
    end else if (cmd.round) begin
      x_reg <= y;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      sample_out    <= x_reg;
      block_end_out <= block_end_reg;
    end
  end

endmodule

`default_nettype wire
